[rtl/core/bcff_pkg.sv]
`default_nettype none

package bcff_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

    localparam int HANDLE_W = 48;
    localparam int BYTES_W  = 32;
    localparam int FUNC_W   = 2;

    localparam logic [BYTES_W-1:0] MAX_TOTAL_RESET = 32'd65536;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_EVICT  = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    // Write port of the slot store.
    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   idx;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
    } slot_wr_t;

endpackage

`default_nettype wire

[rtl/core/bcff_slot_store.sv]
`default_nettype none

// Handle and size storage for the cache slots. One write port, one read
// port with registered read data.
module bcff_slot_store (
    input  wire logic                          clk,
    input  wire bcff_pkg::slot_wr_t            wr,
    input  wire logic [bcff_pkg::SLOT_W-1:0]   rd_idx,
    output logic      [bcff_pkg::HANDLE_W-1:0] rd_handle,
    output logic      [bcff_pkg::BYTES_W-1:0]  rd_bytes
);

    logic [bcff_pkg::HANDLE_W-1:0] handle_mem [bcff_pkg::MAX_ENTRIES];
    logic [bcff_pkg::BYTES_W-1:0]  bytes_mem  [bcff_pkg::MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            handle_mem[wr.idx] <= wr.handle;
            bytes_mem[wr.idx]  <= wr.bytes;
        end
        rd_handle <= handle_mem[rd_idx];
        rd_bytes  <= bytes_mem[rd_idx];
    end

endmodule

`default_nettype wire

[rtl/core/block_cache_first_fit.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  func, block_handle, block_bytes, request_bytes
// out       source     out_valid / out_stall ok, out_handle, out_bytes
// cfg       sink       cfg_wr_en            cfg_wr_data (max_total_bytes)
//
// An item passes from acceptance to its result through the limit check, the
// serial scan over the single read port of the slot store, one slot at a time,
// and the load of the output register. The input stalls while an item is in
// work; a result may wait in the output register while the next item is taken.
// Reset empties the cache (valid bits, count, byte total) and restores the
// limit to 65536.
module block_cache_first_fit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_wr_en,
    input  wire logic [bcff_pkg::BYTES_W-1:0]  cfg_wr_data,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bcff_pkg::FUNC_W-1:0]   func,
    input  wire logic [bcff_pkg::HANDLE_W-1:0] block_handle,
    input  wire logic [bcff_pkg::BYTES_W-1:0]  block_bytes,
    input  wire logic [bcff_pkg::BYTES_W-1:0]  request_bytes,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ok,
    output logic      [bcff_pkg::HANDLE_W-1:0] out_handle,
    output logic      [bcff_pkg::BYTES_W-1:0]  out_bytes
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_PUSH
    } state_t;

    localparam logic [bcff_pkg::SLOT_W-1:0] LAST_IDX =
        bcff_pkg::SLOT_W'(bcff_pkg::MAX_ENTRIES - 1);
    localparam logic [bcff_pkg::COUNT_W-1:0] FULL_COUNT =
        bcff_pkg::COUNT_W'(bcff_pkg::MAX_ENTRIES);

    state_t                          state_reg, state_next;
    logic [bcff_pkg::SLOT_W-1:0]     idx_reg, idx_next;
    logic [bcff_pkg::MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [bcff_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [bcff_pkg::BYTES_W-1:0]    held_reg, held_next;
    logic [bcff_pkg::BYTES_W-1:0]    max_total_reg;

    bcff_pkg::func_t                 func_reg;
    logic [bcff_pkg::HANDLE_W-1:0]   handle_reg;
    logic [bcff_pkg::BYTES_W-1:0]    bytes_reg;
    logic [bcff_pkg::BYTES_W-1:0]    req_reg;

    logic                            res_ok_reg, res_ok_next;
    logic [bcff_pkg::HANDLE_W-1:0]   res_handle_reg, res_handle_next;
    logic [bcff_pkg::BYTES_W-1:0]    res_bytes_reg, res_bytes_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            ok_reg;
    logic [bcff_pkg::HANDLE_W-1:0]   out_handle_reg;
    logic [bcff_pkg::BYTES_W-1:0]    out_bytes_reg;

    logic [bcff_pkg::HANDLE_W-1:0]   rd_handle;
    logic [bcff_pkg::BYTES_W-1:0]    rd_bytes;
    bcff_pkg::slot_wr_t              slot_wr;

    logic                            in_accept;
    logic                            out_free;
    logic                            slot_hit;
    logic                            over_limit;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    // The sum is taken one bit wider so that it cannot wrap.
    assign over_limit = ({1'b0, held_reg} + {1'b0, bytes_reg}) > {1'b0, max_total_reg};

    // Shared test unit of the scan: decides whether the slot under the
    // scan index is the one the operation wants.
    always_comb
    begin
        unique case (func_reg)
            bcff_pkg::FUNC_ADD:   slot_hit = !valid_reg[idx_reg];
            bcff_pkg::FUNC_EVICT: slot_hit = valid_reg[idx_reg];
            bcff_pkg::FUNC_QUERY: slot_hit = valid_reg[idx_reg] && (rd_bytes >= req_reg);
            default:              slot_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        held_next       = held_reg;
        res_ok_next     = res_ok_reg;
        res_handle_next = res_handle_reg;
        res_bytes_next  = res_bytes_reg;
        out_valid_next  = out_valid_reg && out_stall;
        slot_wr         = '{en: 1'b0, idx: idx_reg, handle: handle_reg, bytes: bytes_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // The read of slot zero is issued here so its data is ready
                // in the first scan cycle.
                idx_next        = '0;
                res_ok_next     = 1'b0;
                res_handle_next = '0;
                res_bytes_next  = '0;
                if (func_reg == bcff_pkg::FUNC_UNUSED)
                begin
                    state_next = S_PUSH;
                end
                else if (func_reg == bcff_pkg::FUNC_ADD &&
                         (count_reg >= FULL_COUNT || over_limit))
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (slot_hit)
                begin
                    state_next  = S_PUSH;
                    res_ok_next = 1'b1;
                    if (func_reg == bcff_pkg::FUNC_ADD)
                    begin
                        slot_wr.en          = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        count_next          = count_reg + 1'b1;
                        held_next           = held_reg + bytes_reg;
                    end
                    else
                    begin
                        res_handle_next     = rd_handle;
                        res_bytes_next      = rd_bytes;
                        valid_next[idx_reg] = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        held_next = held_reg - rd_bytes;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            held_reg       <= '0;
            max_total_reg  <= bcff_pkg::MAX_TOTAL_RESET;
            out_valid_reg  <= 1'b0;
            ok_reg         <= 1'b0;
            out_handle_reg <= '0;
            out_bytes_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_total_reg <= cfg_wr_data;
            end
            if (state_reg == S_PUSH && out_free)
            begin
                ok_reg         <= res_ok_reg;
                out_handle_reg <= res_handle_reg;
                out_bytes_reg  <= res_bytes_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        res_ok_reg     <= res_ok_next;
        res_handle_reg <= res_handle_next;
        res_bytes_reg  <= res_bytes_next;
        if (in_accept)
        begin
            func_reg   <= bcff_pkg::func_t'(func);
            handle_reg <= block_handle;
            bytes_reg  <= block_bytes;
            req_reg    <= request_bytes;
        end
    end

    bcff_slot_store u_store (
        .clk       (clk),
        .wr        (slot_wr),
        .rd_idx    (idx_next),
        .rd_handle (rd_handle),
        .rd_bytes  (rd_bytes)
    );

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign out_handle = out_handle_reg;
    assign out_bytes  = out_bytes_reg;

endmodule

`default_nettype wire
